// ===== rtl/chs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and codes for the chained hash set: item layouts, command and
// status codes, and the control bundle from the row update logic.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int KEY_W     = 31;
  localparam int CHUNK_W   = 8;
  localparam int NUM_CHUNKS = (KEY_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W     = NUM_CHUNKS * CHUNK_W;
  localparam int CNT_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  localparam logic [1:0] CMD_FIND   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic      wr_en;
    out_item_t res;
  } upd_ctrl_t;

endpackage : chs_pkg
`default_nettype wire

// ===== rtl/chained_hash_set.sv =====
`default_nettype none
// Flow: an accepted item goes through the byte-serial key modulo unit (its
//   last step also reads the bucket row), then to the row update and write-back.
//   No new item is taken until the current one leaves the update step, which
//   waits while the output register holds an untaken result.
// Reset: asynchronous, active low; clears all per-row valid flags, so every
//   bucket reads as empty. No clearing pass: items are taken right away.
// ----------------------------------------------------------------------------
// chained_hash_set
// Hash set of 31-bit keys with NUM_BUCKETS buckets of BUCKET_SLOTS slots each.
// Each item is a find, an insert or a delete; one result item per input item.
// ----------------------------------------------------------------------------
module chained_hash_set import chs_pkg::*; #(
  parameter int NUM_BUCKETS  = 7,
  parameter int BUCKET_SLOTS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int BW = $clog2(NUM_BUCKETS);

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StUpdate
  } state_e;

  state_e    state_q;
  in_item_t  item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic [BW-1:0] bucket_q;

  logic          in_fire;
  logic          out_free;
  logic          calc_done;
  logic [BW-1:0] calc_bucket;
  logic          commit;

  logic [BUCKET_SLOTS-1:0]            rd_valid, new_valid;
  logic [BUCKET_SLOTS-1:0][KEY_W-1:0] rd_keys, new_keys;
  upd_ctrl_t                          upd_ctrl;
  logic                               mem_wr_en;

  // Take a new item only between items; a waiting result does not block it.
  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  // Finish an item once its result has a place in the output register.
  assign commit     = (state_q == StUpdate) && out_free;
  assign mem_wr_en  = commit && upd_ctrl.wr_en;

  chs_bucket_calc #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BW          (BW)
  ) u_bucket_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .key_i    (in_item_i.key),
    .done_o   (calc_done),
    .bucket_o (calc_bucket)
  );

  // Read the bucket row as soon as its index is known; data is ready in
  // StUpdate and holds there while the output stalls.
  chs_row_mem #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .BW           (BW)
  ) u_row_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (calc_done),
    .rd_addr_i  (calc_bucket),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (bucket_q),
    .wr_valid_i (new_valid),
    .wr_keys_i  (new_keys),
    .rd_valid_o (rd_valid),
    .rd_keys_o  (rd_keys)
  );

  chs_row_update #(
    .BUCKET_SLOTS (BUCKET_SLOTS)
  ) u_row_update (
    .item_i      (item_q),
    .row_valid_i (rd_valid),
    .row_keys_i  (rd_keys),
    .new_valid_o (new_valid),
    .new_keys_o  (new_keys),
    .ctrl_o      (upd_ctrl)
  );

  // Sequencer: idle -> bucket calculation -> row update and write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      item_q      <= '0;
      bucket_q    <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      // Drop the result once the consumer takes it, unless a new one replaces it.
      if (out_valid_q && !out_stall_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            item_q  <= in_item_i;
            state_q <= StCalc;
          end
        end
        StCalc: begin
          if (calc_done) begin
            bucket_q <= calc_bucket;
            state_q  <= StUpdate;
          end
        end
        StUpdate: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_item_q  <= upd_ctrl.res;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // A result appears only as the update step of an item completes.
  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StUpdate))
    else $error("result item raised outside the update step");

  // The row is written back only when the result can be registered.
  a_write_with_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> (state_q == StUpdate) && (!out_valid_o || !out_stall_i))
    else $error("row write-back without a committed result");

  // The modulo unit finishes only while an item waits for its bucket.
  a_calc_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    calc_done |-> (state_q == StCalc))
    else $error("bucket index produced outside the calculation step");

  // An accepted item starts the bucket calculation in the next cycle.
  a_accept_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StCalc) && !calc_done)
    else $error("accepted item did not start the bucket calculation");
`endif

endmodule : chained_hash_set
`default_nettype wire

// ===== rtl/chs_bucket_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_bucket_calc
// Iterative key-modulo-bucket-count unit. Consumes the key MSB first, one
// byte per cycle, with a compare-and-subtract per bit.
// ----------------------------------------------------------------------------
module chs_bucket_calc import chs_pkg::*; #(
  parameter int NUM_BUCKETS = 7,
  parameter int BW          = $clog2(NUM_BUCKETS)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [KEY_W-1:0] key_i,
  output logic                  done_o,
  output logic [BW-1:0]         bucket_o
);

  localparam logic [BW:0]       NbVal   = (BW + 1)'(NUM_BUCKETS);
  localparam logic [CNT_W-1:0]  LastCnt = CNT_W'(NUM_CHUNKS - 1);

  logic [PAD_W-1:0] key_q;
  logic [BW-1:0]    rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;

  // Fold in one byte: rem = (2 * rem + bit) mod NUM_BUCKETS per bit.
  always_comb begin
    logic [BW:0]   t;
    logic [BW-1:0] r;
    r = rem_q;
    t = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      t = {r, key_q[PAD_W-1-i]};
      if (t >= NbVal) begin
        t = t - NbVal;
      end
      r = t[BW-1:0];
    end
    rem_d = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      key_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      rem_q  <= '0;
      key_q  <= PAD_W'(key_i);
    end else if (busy_q) begin
      rem_q <= rem_d;
      key_q <= key_q << CHUNK_W;
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign done_o   = busy_q && (cnt_q == LastCnt);
  assign bucket_o = rem_d;

endmodule : chs_bucket_calc
`default_nettype wire

// ===== rtl/chs_row_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_row_mem
// Bucket row memory: one row per bucket holding all slot keys and slot valid
// bits. One read and one write port, registered read data. A per-row flag,
// cleared at reset, makes a never-written row read as empty.
// ----------------------------------------------------------------------------
module chs_row_mem import chs_pkg::*; #(
  parameter int NUM_BUCKETS  = 7,
  parameter int BUCKET_SLOTS = 8,
  parameter int BW           = $clog2(NUM_BUCKETS)
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  rd_en_i,
  input  wire logic [BW-1:0]                         rd_addr_i,
  input  wire logic                                  wr_en_i,
  input  wire logic [BW-1:0]                         wr_addr_i,
  input  wire logic [BUCKET_SLOTS-1:0]               wr_valid_i,
  input  wire logic [BUCKET_SLOTS-1:0][KEY_W-1:0]    wr_keys_i,
  output logic [BUCKET_SLOTS-1:0]                    rd_valid_o,
  output logic [BUCKET_SLOTS-1:0][KEY_W-1:0]         rd_keys_o
);

  localparam int RowW = BUCKET_SLOTS * (KEY_W + 1);

  logic [RowW-1:0]        mem_q [NUM_BUCKETS];
  logic [RowW-1:0]        rd_data_q;
  logic [NUM_BUCKETS-1:0] row_valid_q;
  logic                   rd_row_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_valid_i, wr_keys_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q    <= '0;
      rd_row_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_row_valid_q <= row_valid_q[rd_addr_i];
      end
    end
  end

  // Mask slot valid bits of a row that was never written.
  assign rd_valid_o = rd_row_valid_q ? rd_data_q[RowW-1 -: BUCKET_SLOTS] : '0;
  assign rd_keys_o  = rd_data_q[BUCKET_SLOTS*KEY_W-1:0];

endmodule : chs_row_mem
`default_nettype wire

// ===== rtl/chs_row_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chs_row_update
// Compare all slots of a bucket row against the key, pick the lowest free
// slot, and build the modified row and the result item.
// ----------------------------------------------------------------------------
module chs_row_update import chs_pkg::*; #(
  parameter int BUCKET_SLOTS = 8
) (
  input  wire in_item_t                              item_i,
  input  wire logic [BUCKET_SLOTS-1:0]               row_valid_i,
  input  wire logic [BUCKET_SLOTS-1:0][KEY_W-1:0]    row_keys_i,
  output logic [BUCKET_SLOTS-1:0]                    new_valid_o,
  output logic [BUCKET_SLOTS-1:0][KEY_W-1:0]         new_keys_o,
  output upd_ctrl_t                                  ctrl_o
);

  logic [BUCKET_SLOTS-1:0] match_vec, match_oh, free_vec, free_oh;
  logic                    hit, has_free;

  always_comb begin
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      match_vec[s] = row_valid_i[s] && (row_keys_i[s] == item_i.key);
    end
  end

  assign free_vec = ~row_valid_i;
  assign match_oh = match_vec & (~match_vec + BUCKET_SLOTS'(1));
  assign free_oh  = free_vec & (~free_vec + BUCKET_SLOTS'(1));
  assign hit      = |match_vec;
  assign has_free = |free_vec;

  always_comb begin
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      new_keys_o[s] = free_oh[s] ? item_i.key : row_keys_i[s];
    end
  end

  always_comb begin
    new_valid_o         = row_valid_i;
    ctrl_o.wr_en        = 1'b0;
    ctrl_o.res.found    = hit;
    ctrl_o.res.status   = hit ? ST_DONE : ST_NOT_FOUND;
    case (item_i.command)
      CMD_INSERT: begin
        if (hit) begin
          ctrl_o.res.status = ST_DUPLICATE;
        end else if (has_free) begin
          new_valid_o       = row_valid_i | free_oh;
          ctrl_o.wr_en      = 1'b1;
          ctrl_o.res.status = ST_DONE;
        end else begin
          ctrl_o.res.status = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          new_valid_o  = row_valid_i & ~match_oh;
          ctrl_o.wr_en = 1'b1;
        end
      end
      default: begin
        // find, and the unused code, only report
        ctrl_o.wr_en = 1'b0;
      end
    endcase
  end

endmodule : chs_row_update
`default_nettype wire

// ===== dv/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for chained_hash_set. Each item runs through a software
// copy of the bucket slots, and every result item is compared field by field
// with the oldest expected one. A directed run comes first, then random traffic
// mostly on a small key pool with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import chs_pkg::*;

  localparam int N_BUCKETS  = 7;
  localparam int N_SLOTS    = 8;
  localparam int N_CELLS    = N_BUCKETS * N_SLOTS;
  localparam int RAND_ITEMS = 400;
  localparam int POOL_SIZE  = 84;
  localparam int IDLE_PCT   = 38;

  // Command 3 is not defined by the block; it must act as a find.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  chained_hash_set #(
    .NUM_BUCKETS (N_BUCKETS),
    .BUCKET_SLOTS(N_SLOTS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Mirror of the bucket slots. Keys are only looked at where the valid bit
  // is set, so an unwritten key never matters.
  logic [KEY_W-1:0] slot_key_q [N_CELLS];
  logic             slot_used_q[N_CELLS];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int  items_total;
  int  items_in;
  int  fail_cnt;
  bit  in_fire;
  bit  hold_done;
  int  hold_left;

  // Both sides stop idling over a stretch of the random traffic.
  wire quiet_phase = (items_in >= 250) && (items_in < 330);

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one operation to the slot mirror and return the result it causes.
  function automatic out_item_t apply_op(input in_item_t it);
    int        base;
    int        hit;
    int        free_s;
    out_item_t r;
    base   = int'(it.key % N_BUCKETS) * N_SLOTS;
    hit    = -1;
    free_s = -1;
    // Compare the whole row at once; take the lowest free slot for inserts.
    for (int s = 0; s < N_SLOTS; s++) begin
      if (slot_used_q[base+s] && slot_key_q[base+s] == it.key && hit < 0) hit = s;
      if (!slot_used_q[base+s] && free_s < 0) free_s = s;
    end
    r.found = (hit >= 0);
    case (it.command)
      CMD_INSERT: begin
        if (hit >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (free_s < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_key_q[base+free_s]  = it.key;
          slot_used_q[base+free_s] = 1'b1;
          r.status = ST_DONE;
        end
      end
      CMD_DELETE: begin
        if (hit >= 0) begin
          slot_used_q[base+hit] = 1'b0;
          r.status = ST_DONE;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        r.status = (hit >= 0) ? ST_DONE : ST_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  task automatic queue_item(input logic [1:0] cmd, input logic [KEY_W-1:0] key);
    in_item_t it;
    it.command = cmd;
    it.key     = key;
    pending_items.push_back(it);
  endtask

  // Sender: advance to the next item only once the current one is taken,
  // and hold the payload while the block stalls.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (pending_items.size() > 0 &&
          (quiet_phase || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid_i <= 1'b1;
        in_item_i  <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  // and has to stall its input while items keep coming.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!hold_done && items_in >= 150) begin
      hold_done = 1'b1;
      hold_left = 200;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_phase && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: predict on every accepted input item, then check every accepted
  // result item against the oldest prediction. One block keeps the order.
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    in_fire = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_op(in_item_i));
        items_in = items_in + 1;
        in_fire  = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with no expected item pending: found %0d status %0d",
                 out_item_o.found, out_item_o.status);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, out_item_o.found);
            fail_cnt = fail_cnt + 1;
          end
          if (out_item_o.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, out_item_o.status);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    logic [KEY_W-1:0] key;
    logic [1:0]       cmd;
    int               roll;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    items_in    = 0;
    fail_cnt    = 0;
    in_fire     = 1'b0;
    hold_done   = 1'b0;
    hold_left   = 0;
    for (int i = 0; i < N_CELLS; i++) begin
      slot_key_q[i]  = '0;
      slot_used_q[i] = 1'b0;
    end

    // Directed: empty set, smallest and largest key, duplicate, unused command.
    queue_item(CMD_FIND,   31'd0);
    queue_item(CMD_INSERT, 31'd0);
    queue_item(CMD_INSERT, 31'd0);
    queue_item(CMD_FIND,   31'd0);
    queue_item(CMD_INSERT, 31'h7FFF_FFFF);
    queue_item(CMD_UNUSED, 31'h7FFF_FFFF);
    // Fill bucket zero, then overflow it.
    for (int k = 1; k < N_SLOTS; k++) queue_item(CMD_INSERT, 31'(k * N_BUCKETS));
    queue_item(CMD_INSERT, 31'(N_SLOTS * N_BUCKETS));
    // Hit in the middle of the row, delete next to it, reuse the freed slot.
    queue_item(CMD_FIND,   31'(4 * N_BUCKETS));
    queue_item(CMD_DELETE, 31'(3 * N_BUCKETS));
    queue_item(CMD_DELETE, 31'(3 * N_BUCKETS));
    queue_item(CMD_INSERT, 31'(N_SLOTS * N_BUCKETS));
    queue_item(CMD_DELETE, 31'h7FFF_FFFF);
    queue_item(CMD_UNUSED, 31'h5555_5555);
    queue_item(CMD_DELETE, 31'd0);

    // Random: mostly keys from a small pool so rows fill, hit and drain,
    // some keys over the full range to exercise every key bit.
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        key = KEY_W'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 45)      cmd = CMD_INSERT;
      else if (roll < 70) cmd = CMD_FIND;
      else if (roll < 95) cmd = CMD_DELETE;
      else                cmd = CMD_UNUSED;
      queue_item(cmd, key);
    end
    items_total = pending_items.size();

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: everything sent, everything answered, then watch for strays.
    wait (items_in == items_total);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** chained_hash_set: PASSED **");
    end else begin
      $display("** chained_hash_set: FAILED **");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("** chained_hash_set: FAILED **");
    $finish;
  end

endmodule : tb_top
`default_nettype wire

// ===== chained_hash_set.f =====
rtl/chs_pkg.sv
rtl/chs_bucket_calc.sv
rtl/chs_row_mem.sv
rtl/chs_row_update.sv
rtl/chained_hash_set.sv
dv/tb_top.sv
